/* hdl/dtc_pkg.sv */
// Shared types, constants and the month length table for the day-count to date converter.
package dtc_pkg;

  // Class of a day count, decided by the front end.
  typedef enum logic [1:0] {
    KIND_JULIAN = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_GREG   = 2'd2
  } dtc_kind_e;

  localparam int unsigned KIND_W = 2;

  // Calendar constants.
  localparam int unsigned LAST_JULIAN_DAY = 2299160;
  localparam int unsigned REST_OF_1582    = 78;
  localparam int unsigned JUL_CYCLE_DAYS  = 1461;
  localparam int unsigned GREG_CYCLE_DAYS = 146097;

  // Remainder register width; it holds anything below one Gregorian cycle.
  localparam int unsigned REM_W  = 18;
  localparam int unsigned YEAR_W = 23;

  // One finished date as it leaves the block.
  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              bc;
  } dtc_date_t;

  // Length of a month in a common year, January is 1.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                        len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      default:                     len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/dtc_front.sv */
// Front end: accepts a day count and classifies it by calendar rule.
module dtc_front #(
  parameter int unsigned DAY_BITS = 31
) (
  input  logic                  push_i,
  input  logic [DAY_BITS-1:0]   day_number_i,
  input  logic                  queue_full_i,
  output logic                  queue_push_o,
  output dtc_pkg::dtc_kind_e    kind_o,
  output logic [DAY_BITS-1:0]   value_o
);

  localparam logic [DAY_BITS-1:0] LastJul   = DAY_BITS'(dtc_pkg::LAST_JULIAN_DAY);
  localparam logic [DAY_BITS-1:0] FirstGreg = DAY_BITS'(dtc_pkg::LAST_JULIAN_DAY + 1);
  localparam logic [DAY_BITS-1:0] Rest1582  = DAY_BITS'(dtc_pkg::REST_OF_1582);

  logic [DAY_BITS-1:0] greg_off;

  // A transaction is taken whenever the queue has room.
  assign queue_push_o = push_i && !queue_full_i;

  // Offset from 15 October 1582 for the Gregorian side.
  assign greg_off = day_number_i - FirstGreg;

  // Julian days pass unchanged, the rest of 1582 and later days as offsets.
  always_comb begin
    if (day_number_i <= LastJul) begin
      kind_o  = dtc_pkg::KIND_JULIAN;
      value_o = day_number_i;
    end else if (greg_off < Rest1582) begin
      kind_o  = dtc_pkg::KIND_SWITCH;
      value_o = greg_off;
    end else begin
      kind_o  = dtc_pkg::KIND_GREG;
      value_o = greg_off - Rest1582;
    end
  end

endmodule

/* hdl/dtc_fifo.sv */
// Small queue that decouples the front end from the back end.
module dtc_fifo #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/dtc_back.sv */
// Back end: divides, steps years and months, and holds the finished date.
module dtc_back #(
  parameter int unsigned DAY_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 queue_empty_i,
  input  dtc_pkg::dtc_kind_e   queue_kind_i,
  input  logic [DAY_BITS-1:0]  queue_value_i,
  output logic                 queue_pop_o,
  input  logic                 pop_i,
  output logic                 out_valid_o,
  output dtc_pkg::dtc_date_t   out_o
);

  localparam int unsigned REM_W  = dtc_pkg::REM_W;
  localparam int unsigned YEAR_W = dtc_pkg::YEAR_W;
  // Widest supported day count; the quotient estimate is sized for it.
  localparam int unsigned X_W    = 40;
  localparam int unsigned QUO_W  = 24;
  localparam int unsigned EST_W  = 24;
  localparam int unsigned EST_PW = 2 * EST_W;
  localparam int unsigned PROD_W = QUO_W + REM_W;
  // Reciprocals rounded down: 2^34 / 1461 and 2^41 / 146097.
  localparam logic [EST_W-1:0] JulRecip  = 24'd11758979;
  localparam logic [EST_W-1:0] GregRecip = 24'd15051802;
  localparam int unsigned JUL_SHIFT  = 34;
  localparam int unsigned GREG_SHIFT = 25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST,
    ST_MULB,
    ST_SUB,
    ST_FIX,
    ST_JUL_YEAR,
    ST_GREG_BASE,
    ST_YEAR_STEP,
    ST_MONTH_STEP,
    ST_FINISH
  } state_e;

  state_e               state_q, state_d;
  dtc_pkg::dtc_kind_e   kind_q, kind_d;
  logic [X_W-1:0]       x_q, x_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [X_W-1:0]       prod_q, prod_d;
  logic [REM_W:0]       part_q, part_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [REM_W-1:0]     div_q, div_d;
  logic [YEAR_W-1:0]    year_q, year_d;
  logic                 bc_q, bc_d;
  logic                 leap_q, leap_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d;
  logic [8:0]           c400_q, c400_d;
  logic [6:0]           c100_q, c100_d;
  logic                 out_valid_q, out_valid_d;
  dtc_pkg::dtc_date_t   out_q, out_d;

  logic [EST_W-1:0]     est_op;
  logic [EST_W-1:0]     est_recip;
  logic [EST_PW-1:0]    est_prod;
  logic [QUO_W-1:0]     quo_est;
  logic [PROD_W-1:0]    back_prod;
  logic [X_W-1:0]       x_diff;
  logic [YEAR_W-1:0]    greg_prod;
  logic                 greg_leap;
  logic [8:0]           year_len;
  logic [8:0]           mon_len;
  logic [6:0]           sw_off;
  logic [10:0]          jul_rem;
  logic [10:0]          jul_q;
  logic signed [13:0]   astro;
  logic [1:0]           jul_off;
  logic [8:0]           jul_drem;
  logic                 out_free;

  // Quotient estimate by reciprocal multiply; it is low by at most one.
  // Julian counts fit in the low bits, Gregorian offsets use the top bits.
  assign est_op    = (kind_q == dtc_pkg::KIND_JULIAN) ? x_q[EST_W-1:0] : x_q[X_W-1:X_W-EST_W];
  assign est_recip = (kind_q == dtc_pkg::KIND_JULIAN) ? JulRecip : GregRecip;
  assign est_prod  = EST_PW'(est_op) * EST_PW'(est_recip);
  assign quo_est   = (kind_q == dtc_pkg::KIND_JULIAN) ? QUO_W'(est_prod[EST_PW-1:JUL_SHIFT])
                                                      : QUO_W'(est_prod[EST_PW-1:GREG_SHIFT]);

  // Multiply back and form the raw remainder, which is below twice the divisor.
  assign back_prod = PROD_W'(quo_q) * PROD_W'(div_q);
  assign x_diff    = x_q - prod_q;

  // Base year of the current 400-year cycle.
  assign greg_prod = quo_q[YEAR_W-1:0] * YEAR_W'(400);

  // Gregorian leap rule from the running year residues.
  assign greg_leap = (c400_q == '0) || ((year_q[1:0] == 2'b00) && (c100_q != '0));
  assign year_len  = greg_leap ? 9'd366 : 9'd365;
  assign mon_len   = {4'b0000, dtc_pkg::month_len(month_q)}
                   + {8'b0, (month_q == 4'd2) && leap_q};

  assign sw_off = queue_value_i[6:0];

  // Julian year within a four-year cycle; the first year of each is leap.
  assign jul_rem = rem_q[10:0];
  assign jul_q   = quo_q[10:0];
  always_comb begin
    if (jul_rem < 11'd366) begin
      jul_off  = 2'd0;
      jul_drem = jul_rem[8:0];
    end else if (jul_rem < 11'd731) begin
      jul_off  = 2'd1;
      jul_drem = 9'(jul_rem - 11'd366);
    end else if (jul_rem < 11'd1096) begin
      jul_off  = 2'd2;
      jul_drem = 9'(jul_rem - 11'd731);
    end else begin
      jul_off  = 2'd3;
      jul_drem = 9'(jul_rem - 11'd1096);
    end
  end
  assign astro = -14'sd4712 + $signed({1'b0, jul_q, 2'b00}) + $signed({12'b0, jul_off});

  assign out_free    = !out_valid_q || pop_i;
  assign queue_pop_o = (state_q == ST_IDLE) && !queue_empty_i;

  // Sequencer next-state and datapath.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    x_d         = x_q;
    quo_d       = quo_q;
    prod_d      = prod_q;
    part_d      = part_q;
    rem_d       = rem_q;
    div_d       = div_q;
    year_d      = year_q;
    bc_d        = bc_q;
    leap_d      = leap_q;
    month_d     = month_q;
    day_d       = day_q;
    c400_d      = c400_q;
    c100_d      = c100_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;

    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          kind_d = queue_kind_i;
          x_d    = X_W'(queue_value_i);
          case (queue_kind_i)
            dtc_pkg::KIND_SWITCH: begin
              // The 78 days after the calendar switch.
              year_d = YEAR_W'(1582);
              bc_d   = 1'b0;
              if (sw_off < 7'd17) begin
                month_d = 4'd10;
                day_d   = 5'(sw_off + 7'd15);
              end else if (sw_off < 7'd47) begin
                month_d = 4'd11;
                day_d   = 5'(sw_off - 7'd16);
              end else begin
                month_d = 4'd12;
                day_d   = 5'(sw_off - 7'd46);
              end
              state_d = ST_FINISH;
            end
            dtc_pkg::KIND_JULIAN: begin
              div_d   = REM_W'(dtc_pkg::JUL_CYCLE_DAYS);
              state_d = ST_EST;
            end
            default: begin
              div_d   = REM_W'(dtc_pkg::GREG_CYCLE_DAYS);
              state_d = ST_EST;
            end
          endcase
        end
      end
      ST_EST: begin
        quo_d   = quo_est;
        state_d = ST_MULB;
      end
      ST_MULB: begin
        prod_d  = back_prod[X_W-1:0];
        state_d = ST_SUB;
      end
      ST_SUB: begin
        part_d  = x_diff[REM_W:0];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        // One compare and subtract brings the remainder below the divisor.
        if (part_q >= {1'b0, div_q}) begin
          rem_d = REM_W'(part_q - {1'b0, div_q});
          quo_d = quo_q + QUO_W'(1);
        end else begin
          rem_d = part_q[REM_W-1:0];
        end
        state_d = (kind_q == dtc_pkg::KIND_JULIAN) ? ST_JUL_YEAR : ST_GREG_BASE;
      end
      ST_JUL_YEAR: begin
        // Astronomical year zero is 1 BC.
        leap_d  = (jul_off == 2'd0);
        rem_d   = {{(REM_W-9){1'b0}}, jul_drem};
        month_d = 4'd1;
        if (astro <= 14'sd0) begin
          bc_d   = 1'b1;
          year_d = YEAR_W'(unsigned'(14'sd1 - astro));
        end else begin
          bc_d   = 1'b0;
          year_d = YEAR_W'(unsigned'(astro));
        end
        state_d = ST_MONTH_STEP;
      end
      ST_GREG_BASE: begin
        // 1583 is 383 past a multiple of 400 and 83 past a multiple of 100.
        year_d  = greg_prod + YEAR_W'(1583);
        bc_d    = 1'b0;
        c400_d  = 9'd383;
        c100_d  = 7'd83;
        state_d = ST_YEAR_STEP;
      end
      ST_YEAR_STEP: begin
        if (rem_q >= {{(REM_W-9){1'b0}}, year_len}) begin
          rem_d  = rem_q - {{(REM_W-9){1'b0}}, year_len};
          year_d = year_q + YEAR_W'(1);
          c400_d = (c400_q == 9'd399) ? '0 : c400_q + 9'd1;
          c100_d = (c100_q == 7'd99) ? '0 : c100_q + 7'd1;
        end else begin
          leap_d  = greg_leap;
          month_d = 4'd1;
          state_d = ST_MONTH_STEP;
        end
      end
      ST_MONTH_STEP: begin
        if ((month_q < 4'd12) && (rem_q >= {{(REM_W-9){1'b0}}, mon_len})) begin
          rem_d   = rem_q - {{(REM_W-9){1'b0}}, mon_len};
          month_d = month_q + 4'd1;
        end else begin
          day_d   = rem_q[4:0] + 5'd1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait until the result register is free or being read.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.day   = day_q;
          out_d.month = month_q;
          out_d.year  = year_q;
          out_d.bc    = bc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, working registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      x_q         <= x_d;
      quo_q       <= quo_d;
      prod_q      <= prod_d;
      part_q      <= part_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      year_q      <= year_d;
      bc_q        <= bc_d;
      leap_q      <= leap_d;
      month_q     <= month_d;
      day_q       <= day_d;
      c400_q      <= c400_d;
      c100_q      <= c100_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/julian_day_to_calendar_date.sv */
// Top level of the day-count to calendar date converter.
//
//   Channel   Handshake       Payload
//   input     push, full      day_number_i
//   result    pop, empty      day_of_month_o, month_number_o,
//                             year_magnitude_o, before_christ_o
//
// The back end divides by the cycle length (reciprocal multiply, multiply back, subtract,
// one correction), then steps Gregorian years (up to 400) and months (up to 12) at one per
// cycle; Julian years come from the four-year table. The last 78 days of 1582 skip the
// division and go straight to the result. Reset empties the queue, idles the sequencer and
// clears the result valid flag.
// A waiting result stalls only the back end; the front queue keeps taking input until it is full.
module julian_day_to_calendar_date #(
  parameter int unsigned DAY_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [DAY_BITS-1:0] day_number_i,
  input  logic                pop,
  output logic                empty,
  output logic [4:0]          day_of_month_o,
  output logic [3:0]          month_number_o,
  output logic [22:0]         year_magnitude_o,
  output logic                before_christ_o
);

  localparam int unsigned ENTRY_W = DAY_BITS + dtc_pkg::KIND_W;

  dtc_pkg::dtc_kind_e   front_kind;
  logic [DAY_BITS-1:0]  front_value;
  logic                 q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0]   q_rdata;
  logic                 out_valid;
  dtc_pkg::dtc_date_t   out_date;

  // Front end classifies each accepted transaction.
  dtc_front #(.DAY_BITS(DAY_BITS)) u_front (
    .push_i       (push),
    .day_number_i (day_number_i),
    .queue_full_i (q_full),
    .queue_push_o (q_push),
    .kind_o       (front_kind),
    .value_o      (front_value)
  );

  // Queue between the two halves.
  dtc_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({front_kind, front_value}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end does the arithmetic and holds the result.
  dtc_back #(.DAY_BITS(DAY_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .queue_kind_i  (dtc_pkg::dtc_kind_e'(q_rdata[ENTRY_W-1:DAY_BITS])),
    .queue_value_i (q_rdata[DAY_BITS-1:0]),
    .queue_pop_o   (q_pop),
    .pop_i         (pop),
    .out_valid_o   (out_valid),
    .out_o         (out_date)
  );

  assign full             = q_full;
  assign empty            = !out_valid;
  assign day_of_month_o   = out_date.day;
  assign month_number_o   = out_date.month;
  assign year_magnitude_o = out_date.year;
  assign before_christ_o  = out_date.bc;

endmodule

/* hdl/dtc_checker.sv */
// Port-level checks for the converter and their binding to the top level.
module dtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pop,
  input logic        empty,
  input logic [4:0]  day_of_month_o,
  input logic [3:0]  month_number_o,
  input logic [22:0] year_magnitude_o,
  input logic        before_christ_o
);

  // A shown month is a real month.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (month_number_o >= 4'd1) && (month_number_o <= 4'd12))
    else $error("month out of range");

  // A shown day never starts at zero.
  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (day_of_month_o != 5'd0))
    else $error("day of month is zero");

  // February never runs past day 29.
  a_feb_days: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (month_number_o == 4'd2)) |-> (day_of_month_o <= 5'd29))
    else $error("February day out of range");

  // BC years lie between 1 and 4713.
  a_bc_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && before_christ_o) |->
      (year_magnitude_o >= 23'd1) && (year_magnitude_o <= 23'd4713))
    else $error("BC year out of range");

  // A result that is not taken stays unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(day_of_month_o) && $stable(month_number_o)
      && $stable(year_magnitude_o) && $stable(before_christ_o))
    else $error("pending result changed");

endmodule

bind julian_day_to_calendar_date dtc_checker u_dtc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pop              (pop),
  .empty            (empty),
  .day_of_month_o   (day_of_month_o),
  .month_number_o   (month_number_o),
  .year_magnitude_o (year_magnitude_o),
  .before_christ_o  (before_christ_o)
);

/* tb/dtc_date_checker.sv */
// Checker that predicts and compares the calendar dates produced by the converter.
`timescale 1ns / 1ps

module dtc_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [30:0] day_number_i,
  input  logic        pop,
  input  logic        empty,
  input  logic [4:0]  day_of_month_o,
  input  logic [3:0]  month_number_o,
  input  logic [22:0] year_magnitude_o,
  input  logic        before_christ_o,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  // Dates still owed by the block, oldest first.
  dtc_pkg::dtc_date_t expected_dates [$];
  int                 error_count;
  int                 checked_count;

  // Days in month m; February gets its extra day in a leap year.
  function automatic int days_in_month(input int m, input bit leap);
    int n;
    case (m)
      2:             n = leap ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic bit is_gregorian_leap(input longint unsigned yr);
    return (yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0);
  endfunction

  // Turns a zero-based day offset inside a year into month and day of month.
  function automatic void place_in_year(input longint unsigned offset, input bit leap,
                                        output logic [3:0] month, output logic [4:0] day);
    longint unsigned left;
    int              m;
    int              len;
    left = offset;
    m    = 1;
    while (m < 12) begin
      len = days_in_month(m, leap);
      if (left < longint'(len)) break;
      left -= len;
      m++;
    end
    month = 4'(m);
    day   = 5'(left + 1);
  endfunction

  // Calendar date for one day count.
  function automatic dtc_pkg::dtc_date_t civil_date_of(input logic [30:0] day_count);
    dtc_pkg::dtc_date_t d;
    longint unsigned    r;
    longint unsigned    rem;
    longint unsigned    yr;
    longint unsigned    span;
    longint             astro;
    bit                 leap;
    r      = day_count;
    d.day  = 5'd1;
    d.month = 4'd1;
    d.year = 23'd1;
    d.bc   = 1'b0;
    if (r <= dtc_pkg::LAST_JULIAN_DAY) begin
      // Julian reckoning in astronomical years: year 0 is 1 BC.
      astro = -4712 + 4 * longint'(r / dtc_pkg::JUL_CYCLE_DAYS);
      rem   = r % dtc_pkg::JUL_CYCLE_DAYS;
      leap  = 1'b1;
      if (rem >= 366) begin
        rem   -= 366;
        astro += 1 + longint'(rem / 365);
        rem    = rem % 365;
        leap   = 1'b0;
      end
      place_in_year(rem, leap, d.month, d.day);
      if (astro <= 0) begin
        d.bc   = 1'b1;
        d.year = 23'(1 - astro);
      end else begin
        d.year = 23'(astro);
      end
    end else begin
      r -= dtc_pkg::LAST_JULIAN_DAY + 1;
      if (r < dtc_pkg::REST_OF_1582) begin
        // The short Gregorian tail of 1582 that follows the switch.
        d.year = 23'd1582;
        if (r < 17) begin
          d.month = 4'd10;
          d.day   = 5'(15 + r);
        end else if (r < 47) begin
          d.month = 4'd11;
          d.day   = 5'(r - 17 + 1);
        end else begin
          d.month = 4'd12;
          d.day   = 5'(r - 47 + 1);
        end
      end else begin
        // Whole 400-year cycles first, then single years.
        r   -= dtc_pkg::REST_OF_1582;
        yr   = 1583 + 400 * (r / dtc_pkg::GREG_CYCLE_DAYS);
        r    = r % dtc_pkg::GREG_CYCLE_DAYS;
        span = is_gregorian_leap(yr) ? 366 : 365;
        while (r >= span) begin
          r   -= span;
          yr++;
          span = is_gregorian_leap(yr) ? 366 : 365;
        end
        place_in_year(r, is_gregorian_leap(yr), d.month, d.day);
        d.year = 23'(yr);
      end
    end
    return d;
  endfunction

  // Compare each result transaction with the oldest expectation, then record new input.
  always @(posedge clk_i) begin
    dtc_pkg::dtc_date_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d/%0d bc=%0b", $time, day_of_month_o,
                   month_number_o, year_magnitude_o, before_christ_o);
          error_count++;
        end else begin
          want = expected_dates.pop_front();
          checked_count++;
          if (day_of_month_o !== want.day) begin
            $display("%0t: day of month expected %0d actual %0d", $time, want.day,
                     day_of_month_o);
            error_count++;
          end
          if (month_number_o !== want.month) begin
            $display("%0t: month expected %0d actual %0d", $time, want.month, month_number_o);
            error_count++;
          end
          if (year_magnitude_o !== want.year) begin
            $display("%0t: year expected %0d actual %0d", $time, want.year,
                     year_magnitude_o);
            error_count++;
          end
          if (before_christ_o !== want.bc) begin
            $display("%0t: BC flag expected %0b actual %0b", $time, want.bc,
                     before_christ_o);
            error_count++;
          end
        end
      end
      if (push && !full) begin
        expected_dates.push_back(civil_date_of(day_number_i));
      end
      errors_o  <= error_count;
      pending_o <= expected_dates.size();
      checked_o <= checked_count;
    end
  end

endmodule

/* tb/tb.sv */
// Top of the converter testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FIRST_GREG_YEAR_DAY = dtc_pkg::LAST_JULIAN_DAY + 1
                                              + dtc_pkg::REST_OF_1582;
  localparam int unsigned LAST_FULL_CYCLE     = 14683;
  localparam int unsigned IDLE_PERCENT        = 32;
  localparam int unsigned HOLD_OFF_CYCLES     = 2000;
  localparam int unsigned RANDOM_ITEMS        = 1395;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [30:0] day_number_i = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_number_o;
  logic [22:0] year_magnitude_o;
  logic        before_christ_o;

  int errors;
  int pending;
  int checked;

  // Shared between the sender and the receiver; hold_off_done is the receiver's own.
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  int julian_sent = 0;
  int switch_sent = 0;
  int greg_sent = 0;

  // Calendar corners: epoch, leap days, 1 BC to 1 AD, the switch and month ends
  // after it, the first 400-year cycle boundary and the top of the day range.
  int unsigned corner_days [$] = '{0, 1, 59, 60, 365, 366, 1460, 1461,
                                   1721057, 1721058, 1721423, 1721424,
                                   2299159, 2299160, 2299161, 2299177, 2299178,
                                   2299207, 2299208, 2299238, 2299239,
                                   2299239 + 146096, 2299239 + 146097,
                                   2147483646, 2147483647};

  always #6 clk_i = ~clk_i;

  julian_day_to_calendar_date i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .day_number_i     (day_number_i),
    .pop              (pop),
    .empty            (empty),
    .day_of_month_o   (day_of_month_o),
    .month_number_o   (month_number_o),
    .year_magnitude_o (year_magnitude_o),
    .before_christ_o  (before_christ_o)
  );

  dtc_date_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .day_number_i     (day_number_i),
    .pop              (pop),
    .empty            (empty),
    .day_of_month_o   (day_of_month_o),
    .month_number_o   (month_number_o),
    .year_magnitude_o (year_magnitude_o),
    .before_christ_o  (before_christ_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Random day count, weighted toward the Julian span, the switch and cycle edges.
  function automatic logic [30:0] pick_day();
    int unsigned     sel;
    longint unsigned base;
    logic [30:0]     d;
    sel = $urandom_range(99);
    if (sel < 25) begin
      d = 31'($urandom_range(dtc_pkg::LAST_JULIAN_DAY, 0));
    end else if (sel < 35) begin
      d = 31'($urandom_range(dtc_pkg::LAST_JULIAN_DAY + 400, dtc_pkg::LAST_JULIAN_DAY - 300));
    end else if (sel < 45) begin
      base = FIRST_GREG_YEAR_DAY
           + longint'(dtc_pkg::GREG_CYCLE_DAYS) * $urandom_range(LAST_FULL_CYCLE);
      if ($urandom_range(1) == 1) d = 31'(base + $urandom_range(800));
      else                        d = 31'(base - 1 - $urandom_range(800));
    end else begin
      d = 31'($urandom);
    end
    return d;
  endfunction

  // Offer one day count and hold it until the block takes it.
  task automatic offer(input logic [30:0] d);
    push         <= 1'b1;
    day_number_i <= d;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (d <= dtc_pkg::LAST_JULIAN_DAY) julian_sent++;
    else if (d < FIRST_GREG_YEAR_DAY)  switch_sent++;
    else                               greg_sent++;
  endtask

  // Idle the input channel for a random number of cycles, except in the steady phase.
  task automatic input_gap();
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      push         <= 1'b0;
      day_number_i <= 31'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Sender: directed corners, then weighted random day counts.
  initial begin
    int unsigned k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corner_days[i]) begin
      input_gap();
      offer(31'(corner_days[i]));
    end
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // The receiver stops for a long while here; the block fills and pushes back.
      if (k == 300) hold_off_req = 1'b1;
      // Let the block drain completely once.
      if (k == 700) begin
        push <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      steady = (k >= 900 && k < 1100);
      input_gap();
      offer(pick_day());
    end
    push <= 1'b0;
    steady = 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (500) @(posedge clk_i);
    $display("Checked %0d dates: %0d Julian, %0d in the 1582 switch window, %0d Gregorian.",
             checked, julian_sent, switch_sent, greg_sent);
    $display("Included one %0d-cycle result stall with input backpressure and one full drain.",
             HOLD_OFF_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random pop with one long hold-off on request.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        pop <= 1'b0;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk_i);
        hold_off_done = 1'b1;
        pop <= 1'b1;
      end else begin
        pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Run limit.
  initial begin
    #40_000_000;
    $display("Timeout with %0d dates outstanding", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
